[hw/rtl/assert_macros.svh]
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define CGEN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define CGEN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    `CGEN_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

[hw/rtl/cgen_pkg.sv]
`default_nettype none

package cgen_pkg;

    // item field widths
    localparam int COUNT_W = 8;
    localparam int VALUE_W = 9;
    localparam int POS_W   = 4;

    // default number of members in a combination
    localparam int ELEMENTS_DEF = 4;

    // register port
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    // register index codes
    localparam logic REG_MAX_VALUE = 1'b0;

    // reset value of max_value
    localparam logic [COUNT_W-1:0] MAX_VALUE_RST = 8'd2;

    typedef logic [COUNT_W-1:0] count_t;

endpackage

`default_nettype wire

[hw/rtl/cgen_if.sv]
`default_nettype none

// request channel
interface cgen_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// result channel
interface cgen_res_if;
    import cgen_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] element_value;
    logic [POS_W-1:0]   position;
    logic               last_of_combo;
    logic               final_combo;

    modport source (output valid, output element_value, output position,
                    output last_of_combo, output final_combo, input ready);
    modport sink   (input valid, input element_value, input position,
                    input last_of_combo, input final_combo, output ready);
endinterface

`default_nettype wire

[hw/rtl/cgen_seq.sv]
`default_nettype none

`include "assert_macros.svh"

module cgen_seq #(
    parameter int ELEMENTS = cgen_pkg::ELEMENTS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire cgen_pkg::count_t max_value,
    cgen_req_if.sink             req,
    cgen_res_if.source           res
);
    import cgen_pkg::*;

    localparam int AW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(ELEMENTS - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT, S_ADV} state_t;

    // count memory and its read register
    count_t mem [ELEMENTS];
    count_t rd_q_reg;

    state_t              state_reg, state_next;
    logic [ELEMENTS-1:0] valid_reg, valid_next;
    logic [AW-1:0]       addr_reg, addr_next;
    logic                issue_reg, issue_next;
    logic                dv_reg, dv_next;
    logic                rd_v_reg;
    logic [AW-1:0]       idx_reg, idx_next;
    count_t              prev_reg, prev_next;
    logic                found_reg, found_next;
    logic [AW-1:0]       diff_idx_reg, diff_idx_next;
    count_t              diff_cnt_reg, diff_cnt_next;
    count_t              cnt0_reg, cnt0_next;
    logic                final_reg, final_next;

    logic               out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [POS_W-1:0]   out_pos_reg, out_pos_next;
    logic               out_last_reg, out_last_next;
    logic               out_final_reg, out_final_next;

    logic          re;
    logic          we;
    logic [AW-1:0] waddr;
    count_t        wdata;
    count_t        rd_data;
    logic          out_free;
    logic          load;
    logic          accept;

    // entry never written since clear reads as zero
    assign rd_data  = rd_v_reg ? rd_q_reg : '0;
    assign out_free = !out_valid_reg || res.ready;
    assign load     = (state_reg == S_EMIT) && dv_reg && out_free;
    assign accept   = req.valid && req.ready;

    assign req.ready         = (state_reg == S_IDLE);
    assign res.valid         = out_valid_reg;
    assign res.element_value = out_value_reg;
    assign res.position      = out_pos_reg;
    assign res.last_of_combo = out_last_reg;
    assign res.final_combo   = out_final_reg;

    // read issue: every cycle in scan, paced by the output in emit
    always_comb
    begin
        re = 1'b0;
        case (state_reg)
            S_SCAN:  re = issue_reg;
            S_EMIT:  re = issue_reg && (!dv_reg || load);
            default: re = 1'b0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        valid_next     = valid_reg;
        addr_next      = addr_reg;
        issue_next     = issue_reg;
        idx_next       = idx_reg;
        prev_next      = prev_reg;
        found_next     = found_reg;
        diff_idx_next  = diff_idx_reg;
        diff_cnt_next  = diff_cnt_reg;
        cnt0_next      = cnt0_reg;
        final_next     = final_reg;
        out_value_next = out_value_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        out_final_next = out_final_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;

        dv_next        = re || ((state_reg == S_EMIT) && dv_reg && !load);
        out_valid_next = load ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);

        // walk the read address down from the last entry
        if (re)
        begin
            idx_next = addr_reg;
            if (addr_reg == '0)
            begin
                issue_next = 1'b0;
            end
            else
            begin
                addr_next = addr_reg - 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.restart)
                    begin
                        valid_next = '0;
                    end
                    found_next = 1'b0;
                    issue_next = 1'b1;
                    addr_next  = LAST_ADDR;
                    state_next = S_SCAN;
                end
            end

            // find the rightmost step and whether all counts match
            S_SCAN:
            begin
                if (dv_reg)
                begin
                    prev_next = rd_data;
                    if ((idx_reg != LAST_ADDR) && (rd_data != prev_reg) && !found_reg)
                    begin
                        found_next    = 1'b1;
                        diff_idx_next = idx_reg + 1'b1;
                        diff_cnt_next = prev_reg;
                    end
                    if (idx_reg == '0)
                    begin
                        cnt0_next  = rd_data;
                        final_next = !found_next && (rd_data >= max_value);
                        issue_next = 1'b1;
                        addr_next  = LAST_ADDR;
                        state_next = S_EMIT;
                    end
                end
            end

            // one member per cycle into the output register while the output is not held
            S_EMIT:
            begin
                if (load)
                begin
                    out_value_next = VALUE_W'(rd_data) + VALUE_W'(LAST_ADDR - idx_reg);
                    out_pos_next   = POS_W'(LAST_ADDR - idx_reg);
                    out_last_next  = (idx_reg == '0);
                    out_final_next = final_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = S_ADV;
                    end
                end
            end

            // step the count vector in colex order
            S_ADV:
            begin
                if (!found_reg)
                begin
                    if (final_reg)
                    begin
                        valid_next = '0;
                    end
                    else
                    begin
                        we         = 1'b1;
                        waddr      = '0;
                        wdata      = cnt0_reg + 1'b1;
                        valid_next = ELEMENTS'(1);
                    end
                end
                else
                begin
                    we    = 1'b1;
                    waddr = diff_idx_reg;
                    wdata = diff_cnt_reg + 1'b1;
                    for (int i = 0; i < ELEMENTS; i++)
                    begin
                        if (AW'(i) == diff_idx_reg)
                        begin
                            valid_next[i] = 1'b1;
                        end
                        else if (AW'(i) > diff_idx_reg)
                        begin
                            valid_next[i] = 1'b0;
                        end
                    end
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // count memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_q_reg <= mem[addr_reg];
        end
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            issue_reg     <= 1'b0;
            dv_reg        <= 1'b0;
            rd_v_reg      <= 1'b0;
            found_reg     <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            issue_reg     <= issue_next;
            dv_reg        <= dv_next;
            found_reg     <= found_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
            if (re)
            begin
                rd_v_reg <= valid_reg[addr_reg];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        addr_reg      <= addr_next;
        idx_reg       <= idx_next;
        prev_reg      <= prev_next;
        diff_idx_reg  <= diff_idx_next;
        diff_cnt_reg  <= diff_cnt_next;
        cnt0_reg      <= cnt0_next;
        out_value_reg <= out_value_next;
        out_pos_reg   <= out_pos_next;
        out_last_reg  <= out_last_next;
        out_final_reg <= out_final_next;
    end

    // checks
    `CGEN_ASSERT(a_idle_quiet, clk, rst_n, (state_reg == S_IDLE) |-> (!dv_reg && !issue_reg))
    `CGEN_ASSERT_NEXT(a_adv_to_idle, clk, rst_n, state_reg == S_ADV, state_reg == S_IDLE)
    `CGEN_ASSERT(a_last_pos, clk, rst_n, (out_valid_reg && out_last_reg) |-> (out_pos_reg == POS_W'(ELEMENTS - 1)))

endmodule

`default_nettype wire

[hw/rtl/colex_combination_generator_core.sv]
// colex combination generator
// req channel: one item carries restart; restart high starts over at the
// first combination, low emits the next one in colex order
// res channel: each request yields ELEMENTS items, members in ascending
// order with position, last_of_combo on the top member and final_combo on
// every member of the combination just before the wrap to all zeros
// config: max_value at byte address 0 over the apb port, written while idle
// walks: the count memory has one read port and is walked twice per request,
// once to find the step position and once to load the members for output
// reset: counts read as zero and max_value is 2; no clearing pass
// stall: a held output register keeps its member and the member walk waits,
// a new request is taken only after the previous one is fully issued
`default_nettype none

module colex_combination_generator_core #(
    parameter int ELEMENTS = cgen_pkg::ELEMENTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [cgen_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [cgen_pkg::DATA_W-1:0]   pwdata,
    output logic      [cgen_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    cgen_req_if.sink                           req,
    cgen_res_if.source                         res
);
    import cgen_pkg::*;

    count_t max_value_reg;
    logic   wr_en;
    logic   sel_max;

    // register decode on the word address
    assign sel_max = (paddr[2] == REG_MAX_VALUE);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = sel_max ? DATA_W'(max_value_reg) : '0;

    // max_value register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_reg <= MAX_VALUE_RST;
        end
        else if (wr_en && sel_max)
        begin
            max_value_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // sequencer with the count memory
    cgen_seq #(
        .ELEMENTS (ELEMENTS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .max_value (max_value_reg),
        .req       (req),
        .res       (res)
    );

endmodule

`default_nettype wire

[tb/tb_colex_combination_generator_core.sv]
module tb_colex_combination_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import cgen_pkg::*;

    localparam int ELEMENTS      = ELEMENTS_DEF;
    localparam int SETTLE_CYCLES = 2 * ELEMENTS + 12;
    localparam int RUN_LIMIT     = 200000;
    localparam int HOLD_CYCLES   = 400;

    // register map
    localparam logic [PADDR_W-1:0] MAX_VALUE_ADDR = PADDR_W'(4 * REG_MAX_VALUE);
    localparam logic [PADDR_W-1:0] SPARE_ADDR     = PADDR_W'(4);

    typedef struct packed {
        logic [VALUE_W-1:0] element_value;
        logic [POS_W-1:0]   position;
        logic               last_of_combo;
        logic               final_combo;
    } member_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    cgen_req_if req_ch();
    cgen_res_if res_ch();

    // shadow of the block state
    count_t  combo_counts [ELEMENTS];
    count_t  cfg_max = MAX_VALUE_RST;
    member_t combo_members_q [$];

    int fail_cnt  = 0;
    int cycle_cnt = 0;

    // traffic shaping knobs
    bit src_idle_en  = 1'b0;
    bit sink_idle_en = 1'b0;
    int hold_len     = 0;
    int hold_seq     = 0;

    colex_combination_generator_core #(
        .ELEMENTS (ELEMENTS)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .res     (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // emit the current combination, then step the counts in colex order
    function automatic void emit_combination(input logic restart_bit);
        member_t m;
        logic    same;
        logic    fin;
        int      step_pos;
        if (restart_bit)
        begin
            foreach (combo_counts[i])
                combo_counts[i] = '0;
        end
        same = 1'b1;
        step_pos = 0;
        for (int j = 1; j < ELEMENTS; j++)
        begin
            if (combo_counts[j] != combo_counts[0])
                same = 1'b0;
            if (combo_counts[j] != combo_counts[j-1])
                step_pos = j;
        end
        fin = same && (combo_counts[0] >= cfg_max);
        for (int p = 0; p < ELEMENTS; p++)
        begin
            m.element_value = VALUE_W'(combo_counts[ELEMENTS-1-p]) + VALUE_W'(p);
            m.position      = POS_W'(p);
            m.last_of_combo = (p == ELEMENTS - 1);
            m.final_combo   = fin;
            combo_members_q.push_back(m);
        end
        // final combination wraps to zeros, else bump and clear the tail
        if (fin)
        begin
            foreach (combo_counts[i])
                combo_counts[i] = '0;
        end
        else
        begin
            combo_counts[step_pos] = combo_counts[step_pos] + 1'b1;
            for (int i = step_pos + 1; i < ELEMENTS; i++)
                combo_counts[i] = '0;
        end
    endfunction

    // predict on every accepted request item
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            emit_combination(req_ch.restart);
    end

    // compare each accepted result item with the oldest expected member
    always @(posedge clk)
    begin : member_check
        member_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (combo_members_q.size() == 0)
            begin
                $error("unexpected item element_value=%0d position=%0d",
                       res_ch.element_value, res_ch.position);
                fail_cnt++;
            end
            else
            begin
                want = combo_members_q.pop_front();
                if (res_ch.element_value !== want.element_value)
                begin
                    $error("element_value expected %0d actual %0d",
                           want.element_value, res_ch.element_value);
                    fail_cnt++;
                end
                if (res_ch.position !== want.position)
                begin
                    $error("position expected %0d actual %0d",
                           want.position, res_ch.position);
                    fail_cnt++;
                end
                if (res_ch.last_of_combo !== want.last_of_combo)
                begin
                    $error("last_of_combo expected %0d actual %0d",
                           want.last_of_combo, res_ch.last_of_combo);
                    fail_cnt++;
                end
                if (res_ch.final_combo !== want.final_combo)
                begin
                    $error("final_combo expected %0d actual %0d",
                           want.final_combo, res_ch.final_combo);
                    fail_cnt++;
                end
            end
        end
    end

    // result side ready: long holds on request, random gaps when enabled
    initial
    begin : sink_drive
        int gap_left;
        int hold_left;
        int seen_seq;
        gap_left  = 0;
        hold_left = 0;
        seen_seq  = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_seq != seen_seq)
            begin
                seen_seq  = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready = 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                res_ch.ready = 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(1, 14) - 1;
                res_ch.ready = 1'b0;
            end
            else
                res_ch.ready = 1'b1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT)
        begin
            $display("tb_colex_combination_generator_core NOT OK");
            $finish;
        end
    end

    // offer one request item and wait for it to be taken
    task automatic request_combination(input logic restart_bit);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 14) - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid   = 1'b1;
        req_ch.restart = restart_bit;
        do @(posedge clk); while (!req_ch.ready);
    endtask

    // drop valid and wait until every expected member has arrived
    task automatic settle_results();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (combo_members_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == MAX_VALUE_ADDR)
            cfg_max = data[COUNT_W-1:0];
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic check_max_value();
        logic [DATA_W-1:0] got;
        apb_read(MAX_VALUE_ADDR, got);
        if (got !== DATA_W'(cfg_max))
        begin
            $error("max_value expected %0d actual %0d", cfg_max, got);
            fail_cnt++;
        end
    endtask

    task automatic set_max_value(input int value);
        apb_write(MAX_VALUE_ADDR, DATA_W'(value));
        check_max_value();
    endtask

    // default limit straight out of reset
    task automatic test_reset_default();
        check_max_value();
        repeat (3) request_combination(1'b0);
        settle_results();
    endtask

    // writes to an unmapped register leave max_value alone
    task automatic test_spare_register();
        logic [DATA_W-1:0] junk;
        apb_write(SPARE_ADDR, '1);
        apb_write(SPARE_ADDR, '0);
        apb_read(SPARE_ADDR, junk);
        check_max_value();
        request_combination(1'b0);
        settle_results();
    endtask

    // zero limit: every all-equal vector is final and wraps
    task automatic test_zero_limit();
        set_max_value(0);
        repeat (2) request_combination(1'b0);
        settle_results();
    endtask

    // limit of one, full cycle through the wrap after a restart
    task automatic test_unit_limit();
        set_max_value(1);
        request_combination(1'b1);
        repeat (5) request_combination(1'b0);
        settle_results();
    endtask

    // limit dropped below existing counts mid sequence
    task automatic test_lowered_limit();
        set_max_value(3);
        request_combination(1'b1);
        request_combination(1'b0);
        settle_results();
        set_max_value(0);
        repeat (4) request_combination(1'b0);
        settle_results();
    endtask

    // long output hold so the block backs up and stalls its input
    task automatic test_output_backpressure();
        set_max_value(2);
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        hold_len = HOLD_CYCLES;
        hold_seq++;
        repeat (12) request_combination($urandom_range(0, 9) == 0);
        settle_results();
    endtask

    // random traffic over several limits, extremes included
    task automatic test_random_traffic();
        int limit_val;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: limit_val = 1;
                1: limit_val = 255;
                2: limit_val = $urandom_range(2, 7);
                3: limit_val = 0;
                default: limit_val = $urandom_range(0, 5);
            endcase
            set_max_value(limit_val);
            src_idle_en  = (ph % 3 != 2);
            sink_idle_en = (ph % 3 != 1);
            repeat (26) request_combination($urandom_range(0, 9) == 0);
            settle_results();
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_quiet_finish();
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        set_max_value($urandom_range(0, 4));
        repeat (20) request_combination($urandom_range(0, 9) == 0);
        settle_results();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_ch.valid   = 1'b0;
        req_ch.restart = 1'b0;
        foreach (combo_counts[i])
            combo_counts[i] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_default();
        test_spare_register();
        test_zero_limit();
        test_unit_limit();
        test_lowered_limit();
        test_output_backpressure();
        test_random_traffic();
        test_quiet_finish();

        if (fail_cnt == 0)
            $display("tb_colex_combination_generator_core OK");
        else
            $display("tb_colex_combination_generator_core NOT OK");
        $finish;
    end

endmodule
